// ===== src/round_robin_task_scheduler_defines.svh =====
// assertion helpers, clocked on clk and quiet while arst_n is low
`ifndef ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH

// condition holds in the same cycle
`define RRTS_ASSERT_NOW(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// trigger in one cycle implies condition in the next
`define RRTS_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ===== src/rrts_pkg.sv =====
`default_nettype none
package rrts_pkg;

	// task numbers incl. the idle slot for up to 31 tasks
	localparam int unsigned TASK_IDX_W = 5;

	typedef enum logic [2:0] {
		OP_START     = 3'd0,
		OP_TICK      = 3'd1,
		OP_YIELD     = 3'd2,
		OP_DELAY     = 3'd3,
		OP_IDLE_POLL = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		TS_STOPPED = 2'd0,
		TS_DELAYED = 2'd1,
		TS_RUNNING = 2'd3
	} task_state_t;

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} state_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] delay_ms;
	} req_t;

	typedef struct packed {
		logic [2:0] next_task;
		logic       switch_request;
	} rsp_t;

	// broadcast update to every cell
	typedef struct packed {
		logic                  tick;
		logic                  run;
		logic [TASK_IDX_W-1:0] run_idx;
		logic                  stop;
		logic [TASK_IDX_W-1:0] stop_idx;
		logic                  sleep;
		logic [TASK_IDX_W-1:0] sleep_idx;
		logic [31:0]           sleep_val;
	} cell_cmd_t;

	// search carries passed from cell to cell
	typedef struct packed {
		logic run_seen;
		logic hi_seen;
		logic lo_seen;
	} chain_t;

	typedef struct packed {
		logic not_delayed;
		logic run_pick;
		logic hi_pick;
		logic lo_pick;
	} cell_flags_t;

	typedef struct packed {
		logic        go;
		logic [31:0] dividend;
		logic [9:0]  divisor;
	} div_req_t;

endpackage
`default_nettype wire

// ===== src/round_robin_task_scheduler.sv =====
// start, tick, yield and idle poll give their result word in the cycle after acceptance and
// busy stays low, so one such word can be taken every cycle while no delay is in progress
// delay gives its result strobe once the bit-serial divider has loaded, formed the 32-bit
// quotient bit by bit and the result has been applied; busy is high meanwhile
// the result strobe lasts one cycle and cannot be held off by the receiver
// reset: all tasks stopped, selection 0, not started, tick period 1
`default_nettype none
`include "round_robin_task_scheduler_defines.svh"
module round_robin_task_scheduler #(
	parameter int unsigned TASKS = 4
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	input  rrts_pkg::req_t   req,
	output logic             done,
	output rrts_pkg::rsp_t   rsp,
	input  wire              cfg_valid,
	output logic             cfg_ready,
	input  wire  [9:0]       cfg_data
);

	localparam int unsigned IW = rrts_pkg::TASK_IDX_W;
	localparam logic [IW-1:0] IDLE_SLOT = IW'(TASKS);

	rrts_pkg::state_t      state_q, state_n;
	logic [IW-1:0]         sel_q, sel_n;
	logic                  started_q, started_n;
	logic [9:0]            period_q;
	logic                  done_q, done_n;
	rrts_pkg::rsp_t        rsp_q, rsp_n;
	rrts_pkg::cell_cmd_t   cmd;
	rrts_pkg::div_req_t    div_req;
	logic                  div_done;
	logic [31:0]           div_quo;
	logic [IW-1:0]         cur;
	rrts_pkg::chain_t      chain [TASKS+1];
	rrts_pkg::cell_flags_t flags [TASKS];
	logic                  accept;
	logic                  any_run, any_hi, any_lo;
	logic [IW-1:0]         run_idx, hi_idx, lo_idx, succ_idx;
	logic [31:0]           ticks;
	logic                  in_div;
	logic                  quick_acc;

	assign accept = start && !busy;

	assign chain[0] = '0;

	for (genvar g = 0; g < TASKS; g++) begin : g_cell
		rrts_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.my_idx   (IW'(g)),
			.cur      (cur),
			.cmd      (cmd),
			.chain_in (chain[g]),
			.chain_out(chain[g+1]),
			.flags    (flags[g])
		);
	end

	assign any_run = chain[TASKS].run_seen;
	assign any_hi  = chain[TASKS].hi_seen;
	assign any_lo  = chain[TASKS].lo_seen;

	// picks are one-hot, so or-ing the indexes encodes them
	always_comb begin
		run_idx = '0;
		hi_idx  = '0;
		lo_idx  = '0;
		for (int i = 0; i < TASKS; i++) begin
			if (flags[i].run_pick) run_idx = run_idx | IW'(i);
			if (flags[i].hi_pick)  hi_idx  = hi_idx | IW'(i);
			if (flags[i].lo_pick)  lo_idx  = lo_idx | IW'(i);
		end
	end

	// idle poll searches from task 0, everything else from the first running task
	assign cur = (state_q == rrts_pkg::ST_IDLE &&
		req.operation == rrts_pkg::OP_IDLE_POLL) ? '0 : run_idx;

	assign succ_idx = any_hi ? hi_idx : (any_lo ? lo_idx : cur);
	assign ticks    = (div_quo == 32'd0) ? 32'd1 : div_quo;

	rrts_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (div_req),
		.done    (div_done),
		.quotient(div_quo)
	);

	always_comb begin
		state_n   = state_q;
		sel_n     = sel_q;
		started_n = started_q;
		done_n    = 1'b0;
		cmd       = '0;
		div_req.go       = 1'b0;
		div_req.dividend = req.delay_ms;
		div_req.divisor  = period_q;
		rsp_n.switch_request = 1'b0;
		case (state_q)
			rrts_pkg::ST_IDLE: begin
				if (accept) begin
					done_n = 1'b1;
					case (rrts_pkg::op_t'(req.operation))
						rrts_pkg::OP_START: begin
							cmd.run     = 1'b1;
							cmd.run_idx = '0;
							sel_n       = '0;
							started_n   = 1'b1;
						end
						rrts_pkg::OP_TICK: begin
							cmd.tick = started_q;
						end
						rrts_pkg::OP_YIELD: begin
							if (!any_run) begin
								rsp_n.switch_request = 1'b1;
							end else if (succ_idx != run_idx) begin
								cmd.stop     = 1'b1;
								cmd.stop_idx = run_idx;
								cmd.run      = 1'b1;
								cmd.run_idx  = succ_idx;
								sel_n        = succ_idx;
								rsp_n.switch_request = 1'b1;
							end
						end
						rrts_pkg::OP_DELAY: begin
							done_n     = 1'b0;
							div_req.go = 1'b1;
							state_n    = rrts_pkg::ST_DIV;
						end
						rrts_pkg::OP_IDLE_POLL: begin
							if (any_hi || flags[0].not_delayed) begin
								cmd.run     = 1'b1;
								cmd.run_idx = succ_idx;
								sel_n       = succ_idx;
								rsp_n.switch_request = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			rrts_pkg::ST_DIV: begin
				if (div_done) begin
					done_n  = 1'b1;
					state_n = rrts_pkg::ST_IDLE;
					rsp_n.switch_request = 1'b1;
					if (any_run) begin
						cmd.sleep     = 1'b1;
						cmd.sleep_idx = run_idx;
						cmd.sleep_val = ticks;
						if (succ_idx == run_idx) begin
							sel_n = IDLE_SLOT;
						end else begin
							cmd.run     = 1'b1;
							cmd.run_idx = succ_idx;
							sel_n       = succ_idx;
						end
					end
				end
			end
			default: begin
				state_n = rrts_pkg::ST_IDLE;
			end
		endcase
		rsp_n.next_task = sel_n[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rrts_pkg::ST_IDLE;
			sel_q     <= '0;
			started_q <= 1'b0;
			period_q  <= 10'd1;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_n;
			sel_q     <= sel_n;
			started_q <= started_n;
			done_q    <= done_n;
			if (cfg_valid && cfg_ready) begin
				period_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_n;
	end

	assign busy      = (state_q != rrts_pkg::ST_IDLE);
	assign cfg_ready = !busy;
	assign done      = done_q;
	assign rsp       = rsp_q;

	assign in_div    = (state_q == rrts_pkg::ST_DIV);
	assign quick_acc = accept && (req.operation != rrts_pkg::OP_DELAY);

	`RRTS_ASSERT_NOW(a_sel_range, sel_q <= IDLE_SLOT, "selection beyond the idle slot")
	`RRTS_ASSERT_NOW(a_no_strobe_in_div, !(in_div && done_q), "strobe while dividing")
	`RRTS_ASSERT_NEXT(a_quick_result, quick_acc, done_q && !busy, "missing result word")
	`RRTS_ASSERT_NEXT(a_div_result, in_div && div_done, done_q && !busy, "delay result lost")

endmodule
`default_nettype wire

// ===== src/rrts_cell.sv =====
`default_nettype none
module rrts_cell (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire  [rrts_pkg::TASK_IDX_W-1:0]     my_idx,
	input  wire  [rrts_pkg::TASK_IDX_W-1:0]     cur,
	input  rrts_pkg::cell_cmd_t                 cmd,
	input  rrts_pkg::chain_t                    chain_in,
	output rrts_pkg::chain_t                    chain_out,
	output rrts_pkg::cell_flags_t               flags
);

	rrts_pkg::task_state_t state_q, state_n;
	logic [31:0]           count_q, count_n;
	logic                  delayed;
	logic [31:0]           count_dec;

	assign delayed   = (state_q == rrts_pkg::TS_DELAYED);
	assign count_dec = count_q - 32'd1;

	// first running task from cell 0, and first non-delayed task above / below cur
	always_comb begin
		flags.not_delayed = !delayed;
		flags.run_pick    = (state_q == rrts_pkg::TS_RUNNING) && !chain_in.run_seen;
		flags.hi_pick     = !delayed && (my_idx > cur) && !chain_in.hi_seen;
		flags.lo_pick     = !delayed && (my_idx < cur) && !chain_in.lo_seen;
		chain_out.run_seen = chain_in.run_seen || (state_q == rrts_pkg::TS_RUNNING);
		chain_out.hi_seen  = chain_in.hi_seen || (!delayed && (my_idx > cur));
		chain_out.lo_seen  = chain_in.lo_seen || (!delayed && (my_idx < cur));
	end

	always_comb begin
		state_n = state_q;
		count_n = count_q;
		if (cmd.tick && delayed) begin
			count_n = count_dec;
			if (count_dec == 32'd0) begin
				state_n = rrts_pkg::TS_STOPPED;
			end
		end
		if (cmd.sleep && (cmd.sleep_idx == my_idx)) begin
			state_n = rrts_pkg::TS_DELAYED;
			count_n = cmd.sleep_val;
		end else if (cmd.run && (cmd.run_idx == my_idx)) begin
			state_n = rrts_pkg::TS_RUNNING;
		end else if (cmd.stop && (cmd.stop_idx == my_idx)) begin
			state_n = rrts_pkg::TS_STOPPED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrts_pkg::TS_STOPPED;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk) begin
		count_q <= count_n;
	end

endmodule
`default_nettype wire

// ===== src/rrts_div.sv =====
`default_nettype none
module rrts_div (
	input  wire                  clk,
	input  wire                  arst_n,
	input  rrts_pkg::div_req_t   req,
	output logic                 done,
	output logic [31:0]          quotient
);

	logic [9:0]  dvs_q;
	logic [9:0]  rem_q;
	logic [31:0] quo_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [10:0] shifted;
	logic        ge;
	logic [10:0] diff;

	// one quotient bit per cycle, msb first
	assign shifted = {rem_q, quo_q[31]};
	assign ge      = (shifted >= {1'b0, dvs_q});
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			dvs_q <= (req.divisor == 10'd0) ? 10'd1 : req.divisor;
			rem_q <= '0;
			quo_q <= req.dividend;
		end else if (run_q) begin
			rem_q <= ge ? diff[9:0] : shifted[9:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire
